@@ rtl/cfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Command frame receiver package
// Shared types and constants for the framed command receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam logic [7:0]  SYNC_BYTE      = 8'hFF;
    localparam logic [10:0] SILENCE_MAX    = 11'd2047;
    localparam logic [10:0] TIMEOUT_RESET  = 11'd1000;
    localparam logic [7:0]  MAX_SPEED_RST  = 8'd100;
    localparam logic [7:0]  MAX_ANGLE_RST  = 8'd180;
    localparam logic [7:0]  LAST_SEQ_RESET = 8'd255;

    typedef enum logic [1:0] {
        REG_TIMEOUT_MS = 2'd0,
        REG_MAX_SPEED  = 2'd1,
        REG_MAX_ANGLE  = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [10:0] timeout_ms;
        logic [7:0]  max_speed;
        logic [7:0]  max_angle;
    } t_cfg;

    typedef struct packed {
        logic [7:0] speed_ref;
        logic [7:0] angle_ref;
        logic [7:0] buttons;
        logic       drive_enable;
        logic       frame_accepted;
        logic       frame_rejected;
    } t_result;

endpackage
`default_nettype wire

@@ rtl/cfr_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Command frame receiver input channel
// Carries one received byte or one millisecond tick per word.
// ----------------------------------------------------------------------------
interface cfr_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/cfr_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Command frame receiver result channel
// Carries the held references and the frame status of one word.
// ----------------------------------------------------------------------------
interface cfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] speed_ref;
    logic [7:0] angle_ref;
    logic [7:0] buttons;
    logic       drive_enable;
    logic       frame_accepted;
    logic       frame_rejected;

    modport source (output valid, output speed_ref, output angle_ref, output buttons,
                    output drive_enable, output frame_accepted, output frame_rejected,
                    input ready);
    modport sink   (input valid, input speed_ref, input angle_ref, input buttons,
                    input drive_enable, input frame_accepted, input frame_rejected,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/cfr_cfg_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Command frame receiver configuration channel
// Carries one register write per word.
// ----------------------------------------------------------------------------
interface cfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/cfr_frame_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Command frame receiver core
// Frame parser, range and repeat check, held references and link watchdog.
// ----------------------------------------------------------------------------
module cfr_frame_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire cfr_pkg::t_item  i_item,
    input  wire cfr_pkg::t_cfg   i_cfg,
    output cfr_pkg::t_result     o_result
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SPEED   = 3'd1,
        PH_ANGLE   = 3'd2,
        PH_BUTTONS = 3'd3,
        PH_SEQ     = 3'd4
    } t_phase;

    t_phase      r_phase,    n_phase;
    logic [7:0]  r_pend_spd, n_pend_spd;
    logic [7:0]  r_pend_ang, n_pend_ang;
    logic [7:0]  r_pend_btn, n_pend_btn;
    logic [7:0]  r_speed,    n_speed;
    logic [7:0]  r_angle,    n_angle;
    logic [7:0]  r_buttons,  n_buttons;
    logic [7:0]  r_last_seq, n_last_seq;
    logic [10:0] r_silence,  n_silence;
    logic        r_enabled,  n_enabled;
    logic        accepted;
    logic        rejected;

    always_comb begin
        n_phase    = r_phase;
        n_pend_spd = r_pend_spd;
        n_pend_ang = r_pend_ang;
        n_pend_btn = r_pend_btn;
        n_speed    = r_speed;
        n_angle    = r_angle;
        n_buttons  = r_buttons;
        n_last_seq = r_last_seq;
        n_silence  = r_silence;
        n_enabled  = r_enabled;
        accepted   = 1'b0;
        rejected   = 1'b0;
        if (i_item.mode) begin
            if (r_silence != cfr_pkg::SILENCE_MAX) begin
                n_silence = r_silence + 11'd1;
            end
        end else begin
            case (r_phase)
                PH_SPEED: begin
                    n_pend_spd = i_item.rx_byte;
                    n_phase    = PH_ANGLE;
                end
                PH_ANGLE: begin
                    n_pend_ang = i_item.rx_byte;
                    n_phase    = PH_BUTTONS;
                end
                PH_BUTTONS: begin
                    n_pend_btn = i_item.rx_byte;
                    n_phase    = PH_SEQ;
                end
                PH_SEQ: begin
                    if ((i_item.rx_byte != r_last_seq) && (r_pend_spd <= i_cfg.max_speed)
                            && (r_pend_ang <= i_cfg.max_angle)) begin
                        n_speed    = r_pend_spd;
                        n_angle    = r_pend_ang;
                        n_buttons  = r_pend_btn;
                        n_last_seq = i_item.rx_byte;
                        n_enabled  = 1'b1;
                        n_silence  = '0;
                        accepted   = 1'b1;
                    end else begin
                        rejected = 1'b1;
                    end
                    n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = (i_item.rx_byte == cfr_pkg::SYNC_BYTE) ? PH_SPEED : PH_HUNT;
                end
            endcase
        end
        if (n_silence > i_cfg.timeout_ms) begin
            n_enabled = 1'b0;
        end
    end

    assign o_result.speed_ref      = n_speed;
    assign o_result.angle_ref      = n_angle;
    assign o_result.buttons        = n_buttons;
    assign o_result.drive_enable   = n_enabled;
    assign o_result.frame_accepted = accepted;
    assign o_result.frame_rejected = rejected;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_speed    <= '0;
            r_angle    <= '0;
            r_buttons  <= '0;
            r_last_seq <= cfr_pkg::LAST_SEQ_RESET;
            r_silence  <= '0;
            r_enabled  <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_speed    <= n_speed;
            r_angle    <= n_angle;
            r_buttons  <= n_buttons;
            r_last_seq <= n_last_seq;
            r_silence  <= n_silence;
            r_enabled  <= n_enabled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_pend_spd <= n_pend_spd;
            r_pend_ang <= n_pend_ang;
            r_pend_btn <= n_pend_btn;
        end
    end

    // A frame is never both accepted and rejected.
    a_acc_rej_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> !(accepted && rejected))
        else $error("frame both accepted and rejected");

    // Ticks never complete a frame.
    a_tick_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.mode) |-> (!accepted && !rejected))
        else $error("tick completed a frame");

    // An accepted frame always leaves drive enabled.
    a_acc_enables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && accepted) |-> n_enabled)
        else $error("accepted frame without drive enable");

    // An accepted frame clears the silence timer and records its counter.
    a_acc_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && accepted) |=> (r_silence == '0 && r_last_seq == $past(i_item.rx_byte)))
        else $error("accepted frame state not updated");

endmodule
`default_nettype wire

@@ rtl/command_frame_receiver_with_timeout.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Command frame receiver with timeout
// Parses sync-byte framed drive commands and disables drive on link silence.
//
// The input channel takes one word per cycle while the output is not stalled:
// either a received serial byte (mode 0) or a one millisecond tick (mode 1).
// Every input word produces exactly one result word on the output channel with
// the held speed, angle and button references, the drive enable and the frame
// status flags. The configuration channel is always ready and writes the
// timeout and the speed and angle limits; the user must see that it is written
// only while the block is idle, as the block itself does not enforce this. A
// word passes through the input register and then the result register before
// its result is valid. Reset clears the pipeline, the held references, the
// silence timer and drive enable, and loads the register defaults. When the
// receiver stalls, the result register holds its word and the input register
// fills, after which the input channel deasserts ready until the result is
// taken.
// ----------------------------------------------------------------------------
module command_frame_receiver_with_timeout (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cfr_in_if.sink     i_in,
    cfr_cfg_if.sink    i_cfg,
    cfr_out_if.source  o_out
);

    cfr_pkg::t_cfg    r_cfg;
    logic             r_s1_valid;
    cfr_pkg::t_item   r_s1_item;
    logic             r_out_valid;
    cfr_pkg::t_result r_out;
    cfr_pkg::t_result core_result;
    logic             out_load;
    logic             s1_go;
    logic             in_take;

    assign out_load   = !r_out_valid || o_out.ready;
    assign s1_go      = r_s1_valid && out_load;
    assign i_in.ready = !r_s1_valid || out_load;
    assign in_take    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ms <= cfr_pkg::TIMEOUT_RESET;
            r_cfg.max_speed  <= cfr_pkg::MAX_SPEED_RST;
            r_cfg.max_angle  <= cfr_pkg::MAX_ANGLE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                cfr_pkg::REG_TIMEOUT_MS: r_cfg.timeout_ms <= i_cfg.data;
                cfr_pkg::REG_MAX_SPEED:  r_cfg.max_speed  <= i_cfg.data[7:0];
                cfr_pkg::REG_MAX_ANGLE:  r_cfg.max_angle  <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item.mode    <= i_in.mode;
            r_s1_item.rx_byte <= i_in.rx_byte;
        end
        if (s1_go) begin
            r_out <= core_result;
        end
    end

    cfr_frame_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_go),
        .i_item   (r_s1_item),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    assign o_out.valid          = r_out_valid;
    assign o_out.speed_ref      = r_out.speed_ref;
    assign o_out.angle_ref      = r_out.angle_ref;
    assign o_out.buttons        = r_out.buttons;
    assign o_out.drive_enable   = r_out.drive_enable;
    assign o_out.frame_accepted = r_out.frame_accepted;
    assign o_out.frame_rejected = r_out.frame_rejected;

    // The input stage only empties into a result register that can load.
    a_s1_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_load) |=> r_s1_valid)
        else $error("input word lost while result stalled");

    // A word in the input stage moves to the result register when it loads.
    a_s1_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go |=> r_out_valid)
        else $error("result word not produced");

    // A result word shows at most one frame status flag.
    a_out_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.frame_accepted && r_out.frame_rejected))
        else $error("result shows both frame flags");

endmodule
`default_nettype wire
